// ===== design/awb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// awb_pkg
// Shared types, widths and constants of the additive wavetable builder.
// ----------------------------------------------------------------------------
package awb_pkg;

  localparam int TABLE_LEN    = 2048;
  localparam int IDX_W        = 11;
  localparam int MAX_PARTIALS = 64;
  localparam int PART_W       = 6;
  localparam int SMP_W        = 16;
  localparam int MUL_W        = 34;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int SUM_W        = 54;
  localparam int NUM_W        = 56;
  localparam int DEN_W        = 40;
  localparam int QUO_W        = 32;
  localparam int QB_W         = 6;

  // Odd polynomial for sin(pi/2 * x), Q30.
  localparam logic [31:0] SC1  = 32'd1686629713;
  localparam logic [31:0] SC3  = 32'd693598669;
  localparam logic [31:0] SC5  = 32'd85569305;
  localparam logic [31:0] SC7  = 32'd5026995;
  localparam logic [31:0] SC9  = 32'd172272;
  localparam logic [31:0] SC11 = 32'd3864;

  localparam logic CFG_HARMONIC = 1'b0;
  localparam logic CFG_SMOOTH   = 1'b1;

  typedef enum logic [1:0] {
    MODE_BEGIN  = 2'd0,
    MODE_WRITE  = 2'd1,
    MODE_COMMIT = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  typedef enum logic [4:0] {
    S_ROM, S_IDLE, S_CLR, S_DONE,
    C_RD, C_LD,
    A_PART, A_VAL, A_DIV, A_WT, A_RD, A_MUL, A_WR,
    N_RD, N_CHK, N_DIV,
    B_M1, B_M2, B_WR
  } state_t;

  typedef struct packed {
    logic            start;
    logic [QB_W-1:0] qbits;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  // Coefficient fed in at each step of the sine polynomial evaluation.
  function automatic logic [31:0] rom_coef(input logic [2:0] step);
    logic [31:0] c;
    case (step)
      3'd1: c = SC11;
      3'd2: c = SC9;
      3'd3: c = SC7;
      3'd4: c = SC5;
      3'd5: c = SC3;
      3'd6: c = SC1;
      default: c = 32'd0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== design/awb_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// awb_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module awb_mul (
  input  wire logic                                clk,
  input  wire logic signed [awb_pkg::MUL_W-1:0]    a,
  input  wire logic signed [awb_pkg::MUL_W-1:0]    b,
  output logic signed [awb_pkg::PROD_W-1:0]        prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule
`default_nettype wire

// ===== design/awb_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// awb_div
// Restoring divider, one quotient bit per cycle, quotient length chosen
// per request.
// ----------------------------------------------------------------------------
module awb_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire awb_pkg::div_req_t            req,
  input  wire logic [awb_pkg::NUM_W-1:0]    num,
  input  wire logic [awb_pkg::DEN_W-1:0]    den,
  output awb_pkg::div_rsp_t                 rsp
);

  localparam int NUM_W = awb_pkg::NUM_W;
  localparam int DEN_W = awb_pkg::DEN_W;
  localparam int QUO_W = awb_pkg::QUO_W;
  localparam int QB_W  = awb_pkg::QB_W;

  logic             busy;
  logic             done;
  logic [QB_W-1:0]  cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] low;
  logic [QUO_W-1:0] quo;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [6:0]       lsh;

  assign lsh   = 7'(NUM_W) - {1'b0, req.qbits};
  assign trial = {rem, low[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.qbits;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == QB_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The caller guarantees the leading part of the numerator is below the divisor.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= DEN_W'(num >> req.qbits);
      low   <= num << lsh;
      den_q <= den;
      quo   <= '0;
    end else if (busy) begin
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low <= {low[NUM_W-2:0], 1'b0};
      quo <= {quo[QUO_W-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule
`default_nettype wire

// ===== design/additive_wavetable_builder_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// additive_wavetable_builder_unit
// Wavetable builder: loads values, rebuilds the table by direct copy or by
// summing sine partials, blends with the old table and serves reads.
// ----------------------------------------------------------------------------
// A begin that opens loading first clears the load store; write, read and an ignored begin do not.
// Direct commit steps each table entry through C_RD, C_LD, B_M1, B_M2 and B_WR.
// Additive commit runs per partial A_PART, A_VAL, A_DIV (divider, with harmonic
// scaling only) and A_WT, then A_RD, A_MUL and A_WR per entry; then per entry N_RD, N_CHK,
// N_DIV (only for entries that are divided), B_M1, B_M2 and B_WR; all products use one shared multiplier.
// After reset the sine ROM is built and both tables cleared, input stalled.
module additive_wavetable_builder_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   mode,
  input  wire logic [10:0]                  index,
  input  wire logic signed [15:0]           value,
  input  wire logic                         additive,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [15:0]                sample,
  output logic                              accepted,
  input  wire logic                         cfg_write,
  input  wire logic                         cfg_index,
  input  wire logic [15:0]                  cfg_data
);

  localparam int TABLE_LEN = awb_pkg::TABLE_LEN;
  localparam int IDX_W     = awb_pkg::IDX_W;
  localparam int PART_W    = awb_pkg::PART_W;
  localparam int MUL_W     = awb_pkg::MUL_W;
  localparam int PROD_W    = awb_pkg::PROD_W;
  localparam int SUM_W     = awb_pkg::SUM_W;
  localparam int NUM_W     = awb_pkg::NUM_W;
  localparam int DEN_W     = awb_pkg::DEN_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_LEN - 1);

  awb_pkg::state_t state, state_next;

  logic                     in_acc;
  logic [IDX_W-1:0]         cnt;
  logic [2:0]               rstep;
  logic [PART_W-1:0]        part;
  logic [PART_W-1:0]        plast;
  logic [IDX_W-1:0]         phase;
  logic [IDX_W-1:0]         hi_idx;
  logic                     loading_open;
  logic                     harm;
  logic [15:0]              smooth;
  logic                     is_read;
  logic                     res_acc;
  logic                     add_q;
  logic [31:0]              mag;
  logic                     vneg;
  logic                     sneg;
  logic signed [32:0]       w;
  logic [37:0]              norm;
  logic [30:0]              x2;
  logic signed [15:0]       newv;
  logic signed [33:0]       t1;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  awb_pkg::div_req_t        dreq;
  awb_pkg::div_rsp_t        drsp;
  logic [NUM_W-1:0]         dnum;
  logic [DEN_W-1:0]         dden;

  // Memories.
  logic signed [15:0]       dmem [TABLE_LEN];
  logic signed [15:0]       wmem [TABLE_LEN];
  logic signed [15:0]       rmem [TABLE_LEN];
  logic signed [SUM_W-1:0]  smem [TABLE_LEN];
  logic                     dm_we, dm_re, wm_we, wm_re, rm_we, rm_re, sm_we, sm_re;
  logic [IDX_W-1:0]         dm_wa, dm_ra, wm_wa, wm_ra, rm_wa, rm_ra, sm_wa, sm_ra;
  logic signed [15:0]       dm_wd, wm_wd, rm_wd, dm_q, wm_q, rm_q;
  logic signed [SUM_W-1:0]  sm_wd, sm_q;

  // Sine evaluation helpers.
  logic [30:0]              xq;
  logic [29:0]              x0;
  logic [31:0]              hi30;
  logic [32:0]              rnd;
  logic [15:0]              rom_mag;

  // Additive helpers.
  logic [15:0]              vabs;
  logic [PART_W:0]          pnum;
  logic signed [SUM_W-1:0]  sabs;
  logic                     sat;
  logic signed [33:0]       bsum;

  function automatic logic signed [15:0] clamp_q(input logic neg, input logic big,
                                                 input logic [15:0] q);
    logic signed [15:0] r;
    if (big || q > 16'd32767) begin
      r = neg ? 16'sh8000 : 16'sh7FFF;
    end else begin
      r = neg ? -$signed(q) : $signed(q);
    end
    return r;
  endfunction

  awb_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  awb_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .num (dnum),
    .den (dden),
    .rsp (drsp)
  );

  assign in_stall = (state != awb_pkg::S_IDLE) || (out_valid && out_stall);
  assign in_acc   = in_valid && !in_stall;

  assign x0      = {cnt[8:0], 21'd0};
  assign xq      = cnt[9] ? (31'h4000_0000 - {1'b0, x0}) : {1'b0, x0};
  assign hi30    = prod[61:30];
  assign rnd     = {1'b0, hi30} + 33'd16384;
  assign rom_mag = (rnd[32:15] > 18'd32767) ? 16'd32767 : rnd[30:15];

  assign vabs = dm_q[15] ? 16'(-dm_q) : dm_q;
  assign pnum = {1'b0, part} + 1'b1;
  assign sabs = sm_q[SUM_W-1] ? -sm_q : sm_q;
  assign sat  = (state == awb_pkg::N_CHK) &&
                ((NUM_W'({sabs, 1'b0}) + NUM_W'(norm)) >> 16) >= NUM_W'({norm, 1'b0});
  assign bsum = t1 + prod[33:0] + 34'sd32768;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      awb_pkg::S_ROM:  if (rstep == 3'd7 && cnt == LAST) state_next = awb_pkg::S_IDLE;
      awb_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (awb_pkg::mode_t'(mode))
            awb_pkg::MODE_BEGIN:
              state_next = loading_open ? awb_pkg::S_DONE : awb_pkg::S_CLR;
            awb_pkg::MODE_COMMIT:
              state_next = additive ? awb_pkg::A_PART : awb_pkg::C_RD;
            default: state_next = awb_pkg::S_DONE;
          endcase
        end
      end
      awb_pkg::S_CLR:  if (cnt == LAST) state_next = awb_pkg::S_DONE;
      awb_pkg::S_DONE: state_next = awb_pkg::S_IDLE;
      awb_pkg::C_RD:   state_next = awb_pkg::C_LD;
      awb_pkg::C_LD:   state_next = awb_pkg::B_M1;
      awb_pkg::A_PART: state_next = awb_pkg::A_VAL;
      awb_pkg::A_VAL:  state_next = harm ? awb_pkg::A_DIV : awb_pkg::A_WT;
      awb_pkg::A_DIV:  if (drsp.done) state_next = awb_pkg::A_WT;
      awb_pkg::A_WT:   state_next = awb_pkg::A_RD;
      awb_pkg::A_RD:   state_next = awb_pkg::A_MUL;
      awb_pkg::A_MUL:  state_next = awb_pkg::A_WR;
      awb_pkg::A_WR: begin
        if (cnt != LAST) state_next = awb_pkg::A_RD;
        else if (part == plast) state_next = awb_pkg::N_RD;
        else state_next = awb_pkg::A_PART;
      end
      awb_pkg::N_RD:   state_next = awb_pkg::N_CHK;
      awb_pkg::N_CHK:
        state_next = (norm == '0 || sat) ? awb_pkg::B_M1 : awb_pkg::N_DIV;
      awb_pkg::N_DIV:  if (drsp.done) state_next = awb_pkg::B_M1;
      awb_pkg::B_M1:   state_next = awb_pkg::B_M2;
      awb_pkg::B_M2:   state_next = awb_pkg::B_WR;
      awb_pkg::B_WR: begin
        if (cnt == LAST) state_next = awb_pkg::S_DONE;
        else state_next = add_q ? awb_pkg::N_RD : awb_pkg::C_RD;
      end
      default: state_next = awb_pkg::S_IDLE;
    endcase
  end

  // Datapath control: memory ports, multiplier operands, divider requests.
  always_comb begin
    dm_we = 1'b0; dm_wa = cnt; dm_wd = '0; dm_re = 1'b0; dm_ra = cnt;
    wm_we = 1'b0; wm_wa = cnt; wm_wd = '0; wm_re = 1'b0; wm_ra = cnt;
    rm_we = 1'b0; rm_wa = cnt; rm_wd = '0; rm_re = 1'b0; rm_ra = phase;
    sm_we = 1'b0; sm_wa = cnt; sm_wd = '0; sm_re = 1'b0; sm_ra = cnt;
    mul_a = '0;
    mul_b = '0;
    dreq.start = 1'b0;
    dreq.qbits = awb_pkg::QB_W'(32);
    dnum = NUM_W'({vabs, 16'd0});
    dden = DEN_W'(pnum);
    unique case (state)
      awb_pkg::S_ROM: begin
        case (rstep)
          3'd0: begin
            mul_a = MUL_W'(xq);
            mul_b = MUL_W'(xq);
          end
          3'd1: begin
            mul_a = MUL_W'(awb_pkg::rom_coef(rstep));
            mul_b = MUL_W'(prod[60:30]);
          end
          3'd6: begin
            mul_a = MUL_W'(awb_pkg::rom_coef(rstep) - hi30);
            mul_b = MUL_W'(xq);
          end
          3'd7: begin
            rm_we = 1'b1;
            rm_wd = cnt[10] ? -$signed(rom_mag) : $signed(rom_mag);
            dm_we = 1'b1;
            wm_we = 1'b1;
          end
          default: begin
            mul_a = MUL_W'(awb_pkg::rom_coef(rstep) - hi30);
            mul_b = MUL_W'(x2);
          end
        endcase
      end
      awb_pkg::S_IDLE: begin
        if (in_acc && awb_pkg::mode_t'(mode) == awb_pkg::MODE_WRITE) begin
          dm_we = 1'b1;
          dm_wa = index;
          dm_wd = value;
        end
        if (in_acc && awb_pkg::mode_t'(mode) == awb_pkg::MODE_READ) begin
          wm_re = 1'b1;
          wm_ra = index;
        end
      end
      awb_pkg::S_CLR: dm_we = 1'b1;
      awb_pkg::C_RD: begin
        dm_re = 1'b1;
        wm_re = 1'b1;
      end
      awb_pkg::A_PART: begin
        dm_re = 1'b1;
        dm_ra = IDX_W'(part);
      end
      awb_pkg::A_VAL: dreq.start = harm;
      awb_pkg::A_RD: begin
        rm_re = 1'b1;
        sm_re = 1'b1;
      end
      awb_pkg::A_MUL: begin
        mul_a = MUL_W'(w);
        mul_b = MUL_W'(rm_q);
      end
      awb_pkg::A_WR: begin
        sm_we = 1'b1;
        sm_wd = ((part == '0) ? '0 : sm_q) + prod[SUM_W-1:0];
      end
      awb_pkg::N_RD: begin
        sm_re = 1'b1;
        wm_re = 1'b1;
      end
      awb_pkg::N_CHK: begin
        dreq.start = (norm != '0) && !sat;
        dreq.qbits = awb_pkg::QB_W'(16);
        dnum = NUM_W'({sabs, 1'b0}) + NUM_W'(norm);
        dden = DEN_W'({norm, 1'b0});
      end
      awb_pkg::B_M1: begin
        mul_a = MUL_W'(wm_q);
        mul_b = MUL_W'({1'b0, smooth});
      end
      awb_pkg::B_M2: begin
        mul_a = MUL_W'(newv);
        mul_b = MUL_W'(17'h10000 - {1'b0, smooth});
      end
      awb_pkg::B_WR: begin
        wm_we = 1'b1;
        wm_wd = bsum[31:16];
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= awb_pkg::S_ROM;
      cnt          <= '0;
      rstep        <= '0;
      hi_idx       <= '0;
      loading_open <= 1'b0;
      harm         <= 1'b1;
      smooth       <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        if (cfg_index == awb_pkg::CFG_HARMONIC) harm <= cfg_data[0];
        else smooth <= cfg_data;
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        awb_pkg::S_ROM: begin
          rstep <= rstep + 1'b1;
          if (rstep == 3'd7) cnt <= cnt + 1'b1;
        end
        awb_pkg::S_IDLE: begin
          cnt <= '0;
          if (in_acc) begin
            unique case (awb_pkg::mode_t'(mode))
              awb_pkg::MODE_BEGIN: begin
                if (!loading_open) begin
                  loading_open <= 1'b1;
                  hi_idx       <= '0;
                end
              end
              awb_pkg::MODE_WRITE: if (index > hi_idx) hi_idx <= index;
              default: ;
            endcase
          end
        end
        awb_pkg::S_CLR, awb_pkg::A_WR, awb_pkg::B_WR: cnt <= cnt + 1'b1;
        awb_pkg::S_DONE: out_valid <= 1'b1;
        default: ;
      endcase
      if (state == awb_pkg::B_WR && cnt == LAST) loading_open <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    unique case (state)
      awb_pkg::S_ROM: if (rstep == 3'd1) x2 <= prod[60:30];
      awb_pkg::S_IDLE: begin
        if (in_acc) begin
          is_read <= (awb_pkg::mode_t'(mode) == awb_pkg::MODE_READ);
          res_acc <= !(awb_pkg::mode_t'(mode) == awb_pkg::MODE_BEGIN && loading_open);
          add_q   <= additive;
          part    <= '0;
          norm    <= '0;
          plast   <= (hi_idx >= IDX_W'(awb_pkg::MAX_PARTIALS - 1)) ?
                     PART_W'(awb_pkg::MAX_PARTIALS - 1) : hi_idx[PART_W-1:0];
        end
      end
      awb_pkg::S_DONE: begin
        sample   <= is_read ? wm_q : 16'sd0;
        accepted <= res_acc;
      end
      awb_pkg::C_LD: newv <= dm_q;
      awb_pkg::A_VAL: begin
        vneg <= dm_q[15];
        mag  <= {vabs, 16'd0};
      end
      awb_pkg::A_DIV: if (drsp.done) mag <= drsp.quo;
      awb_pkg::A_WT: begin
        // Even partial numbers flip the sign of the weight.
        w     <= (vneg ^ part[0]) ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        norm  <= norm + 38'(mag);
        phase <= '0;
      end
      awb_pkg::A_WR: begin
        phase <= phase + IDX_W'(pnum);
        if (cnt == LAST) part <= part + 1'b1;
      end
      awb_pkg::N_CHK: begin
        sneg <= sm_q[SUM_W-1];
        newv <= (norm == '0) ? 16'sd0 : clamp_q(sm_q[SUM_W-1], 1'b1, 16'd0);
      end
      awb_pkg::N_DIV: if (drsp.done) newv <= clamp_q(sneg, 1'b0, drsp.quo[15:0]);
      awb_pkg::B_M2: t1 <= prod[33:0];
      default: ;
    endcase
  end

  // Memory ports.
  always_ff @(posedge clk) begin
    if (dm_we) dmem[dm_wa] <= dm_wd;
    if (dm_re) dm_q <= dmem[dm_ra];
  end

  always_ff @(posedge clk) begin
    if (wm_we) wmem[wm_wa] <= wm_wd;
    if (wm_re) wm_q <= wmem[wm_ra];
  end

  always_ff @(posedge clk) begin
    if (rm_we) rmem[rm_wa] <= rm_wd;
    if (rm_re) rm_q <= rmem[rm_ra];
  end

  always_ff @(posedge clk) begin
    if (sm_we) smem[sm_wa] <= sm_wd;
    if (sm_re) sm_q <= smem[sm_ra];
  end

`ifndef SYNTHESIS
  a_no_accept_on_full_output: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> !(out_valid && out_stall))
    else $error("transaction accepted while a result is held");

  a_div_start_state: assert property (@(posedge clk) disable iff (rst)
    dreq.start |-> (state == awb_pkg::A_VAL || state == awb_pkg::N_CHK))
    else $error("divider started outside its states");

  a_hi_idx_changes_on_item: assert property (@(posedge clk) disable iff (rst)
    (hi_idx != $past(hi_idx)) |-> $past(in_valid && !in_stall))
    else $error("highest index changed without a transaction");
`endif

endmodule
`default_nettype wire

// ===== tb/additive_wavetable_builder_checker.sv =====
// ----------------------------------------------------------------------------
// additive_wavetable_builder_checker
// Watches the input, result and configuration ports of the wavetable builder.
// It predicts every result from its own model of the stores and the table,
// and compares each result transaction field by field with the oldest one.
// ----------------------------------------------------------------------------
module additive_wavetable_builder_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         mode,
  input  logic [10:0]        index,
  input  logic signed [15:0] value,
  input  logic               additive,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] sample,
  input  logic               accepted,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 errors,
  output int                 pending
);

  typedef struct {
    logic signed [15:0] sample;
    logic               accepted;
  } table_result_t;

  table_result_t      expected_q[$];
  logic signed [15:0] sine_lut[awb_pkg::TABLE_LEN];
  logic signed [15:0] loaded[awb_pkg::TABLE_LEN];
  logic signed [15:0] wavetable[awb_pkg::TABLE_LEN];
  longint             partial_sum[awb_pkg::TABLE_LEN];
  int                 top_index;
  logic               loading;
  logic               harm_scale;
  int                 smooth_weight;

  function automatic longint unsigned quarter_wave(input longint unsigned x);
    longint unsigned x2;
    longint unsigned p;
    x2 = (x * x) >> 30;
    p = 64'(awb_pkg::SC11);
    p = 64'(awb_pkg::SC9) - ((p * x2) >> 30);
    p = 64'(awb_pkg::SC7) - ((p * x2) >> 30);
    p = 64'(awb_pkg::SC5) - ((p * x2) >> 30);
    p = 64'(awb_pkg::SC3) - ((p * x2) >> 30);
    p = 64'(awb_pkg::SC1) - ((p * x2) >> 30);
    return (p * x) >> 30;
  endfunction

  function automatic logic signed [15:0] sine_point(input int k);
    longint unsigned q4;
    longint unsigned quad;
    longint unsigned x;
    longint unsigned v;
    q4 = 4 * k;
    quad = q4 / awb_pkg::TABLE_LEN;
    x = ((q4 % awb_pkg::TABLE_LEN) << 30) / awb_pkg::TABLE_LEN;
    if (quad[0]) x = (64'd1 << 30) - x;
    v = (quarter_wave(x) + 16384) >> 15;
    if (v > 32767) v = 32767;
    return quad[1] ? -16'(v) : 16'(v);
  endfunction

  initial begin
    for (int k = 0; k < awb_pkg::TABLE_LEN; k++) sine_lut[k] = sine_point(k);
  end

  // Rebuilds the table on a commit: direct copy or normalized partial sum,
  // then a rounded blend with the previous table.
  task automatic rebuild_table(input logic from_partials);
    logic signed [15:0] fresh[awb_pkg::TABLE_LEN];
    longint unsigned    norm;
    longint unsigned    mag;
    longint unsigned    m;
    longint unsigned    q;
    longint             w;
    longint             s;
    longint             r;
    longint             blend;
    int                 last;
    int                 v;
    if (from_partials) begin
      norm = 0;
      for (int n = 0; n < awb_pkg::TABLE_LEN; n++) partial_sum[n] = 0;
      last = (top_index < awb_pkg::MAX_PARTIALS - 1) ? top_index
                                                     : awb_pkg::MAX_PARTIALS - 1;
      for (int i = 0; i <= last; i++) begin
        v = loaded[i];
        mag = longint'(v < 0 ? -v : v) << 16;
        if (harm_scale) mag = mag / (i + 1);
        w = longint'(mag);
        if (v < 0) w = -w;
        if ((i + 1) % 2 == 0) w = -w;
        norm += mag;
        for (int n = 0; n < awb_pkg::TABLE_LEN; n++)
          partial_sum[n] += w * longint'(sine_lut[(n * (i + 1)) % awb_pkg::TABLE_LEN]);
      end
      for (int n = 0; n < awb_pkg::TABLE_LEN; n++) begin
        s = partial_sum[n];
        if (norm == 0) begin
          fresh[n] = 0;
        end else begin
          m = (s < 0) ? -s : s;
          q = (2 * m + norm) / (2 * norm);
          if (q > 32768) q = 32768;
          r = (s < 0) ? -longint'(q) : longint'(q);
          if (r > 32767) r = 32767;
          fresh[n] = 16'(r);
        end
      end
    end else begin
      for (int n = 0; n < awb_pkg::TABLE_LEN; n++) fresh[n] = loaded[n];
    end
    for (int n = 0; n < awb_pkg::TABLE_LEN; n++) begin
      blend = longint'(wavetable[n]) * smooth_weight
            + longint'(fresh[n]) * (65536 - smooth_weight) + 32768;
      wavetable[n] = 16'(blend >>> 16);
    end
    loading = 1'b0;
  endtask

  always @(posedge clk) begin
    table_result_t got;
    table_result_t want;
    if (rst) begin
      for (int n = 0; n < awb_pkg::TABLE_LEN; n++) begin
        loaded[n] = 0;
        wavetable[n] = 0;
      end
      top_index = 0;
      loading = 1'b0;
      harm_scale = 1'b1;
      smooth_weight = 0;
      expected_q.delete();
      errors = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == awb_pkg::CFG_HARMONIC) harm_scale = cfg_data[0];
        else smooth_weight = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with no expectation waiting");
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (sample !== want.sample) begin
            $error("sample: expected %0d, got %0d", want.sample, sample);
            errors++;
          end
          if (accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, accepted);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        got.sample = 0;
        got.accepted = 1'b1;
        case (awb_pkg::mode_t'(mode))
          awb_pkg::MODE_BEGIN: begin
            if (loading) begin
              got.accepted = 1'b0;
            end else begin
              for (int n = 0; n < awb_pkg::TABLE_LEN; n++) loaded[n] = 0;
              top_index = 0;
              loading = 1'b1;
            end
          end
          awb_pkg::MODE_WRITE: begin
            loaded[index] = value;
            if (index > top_index) top_index = index;
          end
          awb_pkg::MODE_COMMIT: rebuild_table(additive);
          default: got.sample = wavetable[index];
        endcase
        expected_q.push_back(got);
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== tb/additive_wavetable_builder_unit_tb.sv =====
// ----------------------------------------------------------------------------
// additive_wavetable_builder_unit_tb
// Drives load, commit and read transactions into the wavetable builder with
// random gaps and stalls on both sides, changes the configuration between
// phases, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module additive_wavetable_builder_unit_tb;

  localparam int IDLE_LIMIT = 2000000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         mode;
  logic [10:0]        index;
  logic signed [15:0] value;
  logic               additive;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] sample;
  logic               accepted;
  logic               cfg_write;
  logic               cfg_index;
  logic [15:0]        cfg_data;
  int                 errors;
  int                 pending;
  int                 idle_cycles;
  bit                 no_gaps;
  bit                 hold_req;

  additive_wavetable_builder_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .index(index), .value(value), .additive(additive),
    .out_valid(out_valid), .out_stall(out_stall),
    .sample(sample), .accepted(accepted),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  additive_wavetable_builder_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .index(index), .value(value), .additive(additive),
    .out_valid(out_valid), .out_stall(out_stall),
    .sample(sample), .accepted(accepted),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // A long stretch with no transaction at all means the block has hung.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stall before each transaction, plus one long hold-off.
  initial begin
    int n;
    out_stall = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end
      n = no_gaps ? 0 : $urandom_range(0, 6);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  task automatic send_item(input awb_pkg::mode_t m, input int idx, input int val,
                           input logic add);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    index <= 11'(idx);
    value <= 16'(val);
    additive <= add;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  // Registers are only written once every result is back.
  task automatic write_reg(input logic ri, input int data);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= ri;
    cfg_data <= 16'(data);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int    sm;
    int    items;
    int    roll;
    logic  add;
    rst = 1'b1;
    in_valid = 1'b0;
    mode = awb_pkg::MODE_READ;
    index = '0;
    value = '0;
    additive = 1'b0;
    cfg_write = 1'b0;
    cfg_index = awb_pkg::CFG_HARMONIC;
    cfg_data = '0;
    no_gaps = 1'b0;
    hold_req = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, writes outside loading, ignored begin, extremes.
    send_item(awb_pkg::MODE_READ, 0, 0, 1'b0);
    send_item(awb_pkg::MODE_READ, 2047, 0, 1'b0);
    send_item(awb_pkg::MODE_WRITE, 5, 32767, 1'b0);
    send_item(awb_pkg::MODE_BEGIN, 0, 0, 1'b0);
    send_item(awb_pkg::MODE_BEGIN, 3, 0, 1'b1);
    send_item(awb_pkg::MODE_WRITE, 0, -32768, 1'b0);
    send_item(awb_pkg::MODE_WRITE, 2047, 32767, 1'b1);
    send_item(awb_pkg::MODE_WRITE, 1, 1, 1'b0);
    send_item(awb_pkg::MODE_COMMIT, 0, 0, 1'b0);
    send_item(awb_pkg::MODE_READ, 0, 0, 1'b0);
    send_item(awb_pkg::MODE_READ, 2047, 0, 1'b0);
    send_item(awb_pkg::MODE_READ, 1, 0, 1'b0);
    // Commit with loading closed, highest index past the partial limit.
    send_item(awb_pkg::MODE_COMMIT, 0, 0, 1'b1);
    send_item(awb_pkg::MODE_READ, 0, 0, 1'b0);
    send_item(awb_pkg::MODE_READ, 512, 0, 1'b0);
    send_item(awb_pkg::MODE_READ, 1365, 0, 1'b0);
    write_reg(awb_pkg::CFG_HARMONIC, 0);
    write_reg(awb_pkg::CFG_SMOOTH, 65535);
    send_item(awb_pkg::MODE_BEGIN, 0, 0, 1'b0);
    send_item(awb_pkg::MODE_WRITE, 0, 16384, 1'b0);
    send_item(awb_pkg::MODE_WRITE, 3, -1000, 1'b0);
    send_item(awb_pkg::MODE_COMMIT, 0, 0, 1'b1);
    send_item(awb_pkg::MODE_READ, 100, 0, 1'b0);
    // All-zero partials leave the norm at zero.
    send_item(awb_pkg::MODE_BEGIN, 0, 0, 1'b0);
    send_item(awb_pkg::MODE_COMMIT, 0, 0, 1'b1);
    send_item(awb_pkg::MODE_READ, 1700, 0, 1'b0);

    // Random: load episodes alternating between direct and additive commits.
    for (int ep = 0; ep < 8; ep++) begin
      case (ep)
        0: sm = 0;
        1: sm = 65535;
        default: sm = $urandom_range(0, 65535);
      endcase
      write_reg(awb_pkg::CFG_SMOOTH, sm);
      write_reg(awb_pkg::CFG_HARMONIC, $urandom_range(0, 1));
      no_gaps = (ep == 3 || ep == 6);
      if (ep == 2) hold_req = 1'b1;
      add = ep[0];
      items = $urandom_range(180, 220);
      send_item(awb_pkg::MODE_BEGIN, $urandom_range(0, 2047), $urandom_range(0, 65535),
                1'b0);
      for (int k = 0; k < items; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          // Additive episodes keep few partials so the rebuild stays short.
          send_item(awb_pkg::MODE_WRITE,
                    add ? $urandom_range(0, 3) : $urandom_range(0, 2047),
                    $urandom_range(0, 65535), $urandom_range(0, 1));
        end else if (roll < 95) begin
          send_item(awb_pkg::MODE_READ, $urandom_range(0, 2047), $urandom_range(0, 65535),
                    $urandom_range(0, 1));
        end else begin
          send_item(awb_pkg::MODE_BEGIN, $urandom_range(0, 2047), $urandom_range(0, 65535),
                    $urandom_range(0, 1));
        end
      end
      send_item(awb_pkg::MODE_COMMIT, $urandom_range(0, 2047), $urandom_range(0, 65535),
                add);
      repeat (8) send_item(awb_pkg::MODE_READ, $urandom_range(0, 2047), 0, 1'b0);
      no_gaps = 1'b0;
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/awb_pkg.sv
design/awb_mul.sv
design/awb_div.sv
design/additive_wavetable_builder_unit.sv
tb/additive_wavetable_builder_checker.sv
tb/additive_wavetable_builder_unit_tb.sv
